>>> src/gbb_pkg.sv
package gbb_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MIN_SIZE   = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd2;

  localparam logic [SIZE_W-1:0] RST_SIZE = 12'd1080;
  localparam logic [MODE_W-1:0] RST_MODE = 2'd3;

  // Channel mode codes; any other code behaves as one channel.
  localparam logic [MODE_W-1:0] MODE_TWO   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_THREE = 2'd3;

  // Sum of nine pixels, and reciprocals for the divisions by 3 and by 9.
  localparam int              SUM_W    = 12;
  localparam logic [9:0]      DIV3_MUL = 10'd683;   // 2^11 / 3, rounded up
  localparam logic [12:0]     DIV9_MUL = 13'd7282;  // 2^16 / 9, rounded up

  // Per-item control decided at acceptance time.
  typedef struct packed {
    logic drain;   // item lies past the last pixel of the frame
    logic emit;    // item releases a center pixel
    logic border;  // released center lies on the frame border
    logic last;    // released center is the last one of the frame
  } pos_t;

endpackage

>>> src/gbb_ram.sv
module gbb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/gbb_ctrl.sv
module gbb_ctrl #(
  parameter int MAX_WIDTH  = gbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbb_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 2),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          flush,
  input  logic          restart,
  input  logic [CW-1:0] w_size,
  input  logic [RW-1:0] h_size,
  output logic          load,
  output gbb_pkg::pos_t pos,
  output logic [AW-1:0] col
);

  import gbb_pkg::*;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0] in_col_inc, out_col_inc;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;
  logic          drain;
  logic          emit;
  logic          border;
  logic          last;

  assign w_m1  = w_size - CW'(1);
  assign h_m1  = h_size - RW'(1);
  assign drain = in_row_r >= h_size;

  // A flush tick only counts once the frame's pixels are all in.
  assign load = step && !(flush && !drain);

  assign emit   = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign border = (out_row_r == '0) || (out_row_r >= h_m1) ||
                  (out_col_r == '0) || (out_col_r >= w_m1);
  assign last   = (out_row_r >= h_m1) && (out_col_r >= w_m1);

  assign in_col_inc  = in_col_r + CW'(1);
  assign out_col_inc = out_col_r + CW'(1);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (load) begin
      if (in_col_inc >= w_size) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_inc;
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_inc >= w_size) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign pos.drain  = drain;
  assign pos.emit   = emit;
  assign pos.border = border;
  assign pos.last   = last;
  assign col        = in_col_r[AW-1:0];

endmodule

>>> src/gbb_filter.sv
module gbb_filter #(
  parameter int MAX_WIDTH = gbb_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  gbb_pkg::pos_t               pos,
  input  logic [AW-1:0]               col,
  input  logic [gbb_pkg::PIX_W-1:0]   chan_a,
  input  logic [gbb_pkg::PIX_W-1:0]   chan_b,
  input  logic [gbb_pkg::PIX_W-1:0]   chan_c,
  input  logic [gbb_pkg::MODE_W-1:0]  mode,
  output logic                        busy,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [gbb_pkg::PIX_W-1:0]   out_mean_pixel,
  output logic [gbb_pkg::PIX_W-1:0]   out_gray_pixel,
  output logic                        out_frame_last
);

  import gbb_pkg::*;

  localparam int LW = 2 * PIX_W;

  function automatic logic [PIX_W-1:0] to_gray(input logic [MODE_W-1:0] m,
                                               input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
    logic [9:0]  s3;
    logic [8:0]  s2;
    logic [19:0] p;
    s3 = 10'(a) + 10'(b) + 10'(c);
    s2 = 9'(a) + 9'(b);
    p  = 20'(s3) * 20'(DIV3_MUL);
    case (m)
      MODE_THREE: to_gray = p[18:11];
      MODE_TWO:   to_gray = s2[8:1];
      default:    to_gray = a;
    endcase
  endfunction

  // Stage A: accepted item, line store read in flight.
  logic             a_valid_r, a_valid_nxt;
  pos_t             a_pos_r;
  logic [AW-1:0]    a_col_r;
  logic [PIX_W-1:0] a_chan_a_r, a_chan_b_r, a_chan_c_r;
  logic             fwd_r;
  logic [LW-1:0]    fwd_data_r;
  logic [LW-1:0]    ram_rdata;
  logic [LW-1:0]    a_line;
  logic [LW-1:0]    a_wdata;
  logic [PIX_W-1:0] a_gray;
  logic             a_adv;

  // 3x3 window, indexed [row][column]; column 2 is the newest.
  logic [PIX_W-1:0] win_r [3][3];
  logic [SUM_W-1:0] win_sum;

  // Stage B: window sum and center of one released pixel.
  logic             b_valid_r, b_valid_nxt;
  logic [SUM_W-1:0] b_sum_r;
  logic [PIX_W-1:0] b_center_r;
  logic             b_border_r;
  logic             b_last_r;
  logic             b_free;
  logic [24:0]      b_prod;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_mean_r;
  logic [PIX_W-1:0] out_gray_r;
  logic             out_last_r;
  logic             out_ld;

  assign out_ld = b_valid_r && (!out_valid_r || !out_stall);
  assign b_free = !b_valid_r || out_ld;
  assign a_adv  = a_valid_r && (!a_pos_r.emit || b_free);
  assign busy   = a_valid_r && !a_adv;

  assign a_valid_nxt   = load || (a_valid_r && !a_adv);
  assign b_valid_nxt   = (a_adv && a_pos_r.emit) || (b_valid_r && !out_ld);
  assign out_valid_nxt = out_ld || (out_valid_r && out_stall);

  // Line store word: upper byte is two rows up, lower byte one row up.
  gbb_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_col_r),
    .wdata (a_wdata),
    .re    (load),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // After a frame restart the new item may read the column that the item
  // ahead of it writes in the same cycle; that word is taken from the bypass.
  assign a_line  = fwd_r ? fwd_data_r : ram_rdata;
  assign a_gray  = a_pos_r.drain ? '0 : to_gray(mode, a_chan_a_r, a_chan_b_r, a_chan_c_r);
  assign a_wdata = {a_line[PIX_W-1:0], a_gray};

  always_comb begin
    win_sum = SUM_W'(a_line[LW-1:PIX_W]) + SUM_W'(a_line[PIX_W-1:0]) + SUM_W'(a_gray);
    for (int r = 0; r < 3; r++) begin
      win_sum = win_sum + SUM_W'(win_r[r][1]) + SUM_W'(win_r[r][2]);
    end
  end

  assign b_prod = 25'(b_sum_r) * 25'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        fwd_r <= a_adv && (a_col_r == col);
      end
      if (a_adv) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= a_line[LW-1:PIX_W];
        win_r[1][2] <= a_line[PIX_W-1:0];
        win_r[2][2] <= a_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_pos_r    <= pos;
      a_col_r    <= col;
      a_chan_a_r <= chan_a;
      a_chan_b_r <= chan_b;
      a_chan_c_r <= chan_c;
      fwd_data_r <= a_wdata;
    end
    if (a_adv && a_pos_r.emit) begin
      b_sum_r    <= win_sum;
      b_center_r <= win_r[1][2];
      b_border_r <= a_pos_r.border;
      b_last_r   <= a_pos_r.last;
    end
    if (out_ld) begin
      out_mean_r <= b_border_r ? b_center_r : b_prod[16 +: PIX_W];
      out_gray_r <= b_center_r;
      out_last_r <= b_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_pixel = out_mean_r;
  assign out_gray_pixel = out_gray_r;
  assign out_frame_last = out_last_r;

endmodule

>>> src/gray_box_blur_3x3_unit.sv
// Streaming 3x3 box filter on a gray image.
// Input channel (in_valid / in_stall): pixels of a frame in raster order, each
// with up to three color channels that are averaged into one gray value. After
// the frame's last pixel, flush ticks (in_req_type = 1) drain the remaining
// centers; image_width + 1 of them are needed. A flush tick inside a frame is
// taken and dropped.
// Output channel (out_valid / out_stall): one center pixel per transfer, with
// its 3x3 mean (its own gray value on the frame border), its gray value and a
// flag on the last center of the frame.
// A center leaves once the item image_width + 1 raster places after it has been
// taken, through stages A, B and the output register. One item is taken per
// cycle while in_stall is low: the line store is one RAM with one read and one
// write port, read when an item is taken and written one stage later.
// While the receiver stalls, the output register holds its result and the two
// stages in front keep filling; in_stall rises once they are full.
// Reset restores the registers to 1080 x 1080 with three channels and starts a
// new frame. Writing width or height also starts a new frame; write the
// configuration only between frames.
module gray_box_blur_3x3_unit #(
  parameter int MAX_WIDTH  = gbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [gbb_pkg::PIX_W-1:0]      in_chan_a,
  input  logic [gbb_pkg::PIX_W-1:0]      in_chan_b,
  input  logic [gbb_pkg::PIX_W-1:0]      in_chan_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gbb_pkg::PIX_W-1:0]      out_mean_pixel,
  output logic [gbb_pkg::PIX_W-1:0]      out_gray_pixel,
  output logic                           out_frame_last
);

  import gbb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [SIZE_W-1:0] img_w_r;
  logic [SIZE_W-1:0] img_h_r;
  logic [MODE_W-1:0] mode_r;
  logic [CW-1:0]     w_size;
  logic [RW-1:0]     h_size;
  logic              restart;
  logic              step;
  logic              load;
  pos_t              pos;
  logic [AW-1:0]     col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_SIZE;
      img_h_r <= RST_SIZE;
      mode_r  <= RST_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data[SIZE_W-1:0];
        CFG_CHANNEL_MODE: mode_r  <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sizes are used clamped to the range the line store supports.
  always_comb begin
    if (img_w_r < SIZE_W'(MIN_SIZE)) begin
      w_size = CW'(MIN_SIZE);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_size = CW'(MAX_WIDTH);
    end else begin
      w_size = CW'(img_w_r);
    end
    if (img_h_r < SIZE_W'(MIN_SIZE)) begin
      h_size = RW'(MIN_SIZE);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      h_size = RW'(MAX_HEIGHT);
    end else begin
      h_size = RW'(img_h_r);
    end
  end

  assign restart = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                              (cfg_index == CFG_IMAGE_HEIGHT));
  assign step    = in_valid && !in_stall;

  gbb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .flush   (in_req_type),
    .restart (restart),
    .w_size  (w_size),
    .h_size  (h_size),
    .load    (load),
    .pos     (pos),
    .col     (col)
  );

  gbb_filter #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_filter (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .pos            (pos),
    .col            (col),
    .chan_a         (in_chan_a),
    .chan_b         (in_chan_b),
    .chan_c         (in_chan_c),
    .mode           (mode_r),
    .busy           (in_stall),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_mean_pixel (out_mean_pixel),
    .out_gray_pixel (out_gray_pixel),
    .out_frame_last (out_frame_last)
  );

endmodule

>>> test/gray_box_blur_3x3_unit_tb.sv
`timescale 1ns / 1ps

module gray_box_blur_3x3_unit_tb;
  import gbb_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE = 2'd1;
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] gray;
    logic             last;
  } center_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = 1'b0;
  logic [PIX_W-1:0]      in_chan_a = '0;
  logic [PIX_W-1:0]      in_chan_b = '0;
  logic [PIX_W-1:0]      in_chan_c = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_mean_pixel;
  logic [PIX_W-1:0]      out_gray_pixel;
  logic                  out_frame_last;

  // Predictor state: registers, line stores, window and raster positions.
  logic [SIZE_W-1:0] model_width = RST_SIZE;
  logic [SIZE_W-1:0] model_height = RST_SIZE;
  logic [MODE_W-1:0] model_mode = RST_MODE;
  logic [PIX_W-1:0]  row_store [2*MAXW];
  logic [PIX_W-1:0]  win [3][3];
  int                in_col = 0;
  int                in_row = 0;
  int                out_col = 0;
  int                out_row = 0;

  center_t centers_due[$];
  int      errors = 0;
  int      items_taken = 0;
  int      idle_pct = 15;
  int      stall_pct = 15;

  gray_box_blur_3x3_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_chan_a      (in_chan_a),
    .in_chan_b      (in_chan_b),
    .in_chan_c      (in_chan_c),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_pixel (out_mean_pixel),
    .out_gray_pixel (out_gray_pixel),
    .out_frame_last (out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int frame_w();
    if (model_width < MIN_SIZE) return MIN_SIZE;
    if (model_width > MAXW) return MAXW;
    return model_width;
  endfunction

  function automatic int frame_h();
    if (model_height < MIN_SIZE) return MIN_SIZE;
    if (model_height > MAXH) return MAXH;
    return model_height;
  endfunction

  function automatic void restart_positions();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Advances the filter by one accepted item and queues the center it releases.
  function automatic void blur_accept(input logic req, input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
    int w, h, x, r, k, sum;
    logic drain, emit, is_last;
    logic [PIX_W-1:0] g, mean;
    w = frame_w();
    h = frame_h();
    drain = in_row >= h;
    if (req == REQ_FLUSH && !drain) return;
    items_taken++;
    sum = int'(a) + int'(b) + int'(c);
    if (drain) g = '0;
    else if (model_mode == MODE_THREE) g = PIX_W'(sum / 3);
    else if (model_mode == MODE_TWO) g = PIX_W'((int'(a) + int'(b)) / 2);
    else g = a;

    x = in_col % MAXW;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = row_store[x];
    win[1][2] = row_store[MAXW + x];
    win[2][2] = g;
    row_store[x] = row_store[MAXW + x];
    row_store[MAXW + x] = g;

    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;

    if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1) begin
      mean = win[1][1];
    end else begin
      sum = 0;
      for (r = 0; r < 3; r++)
        for (k = 0; k < 3; k++)
          sum += win[r][k];
      mean = PIX_W'(sum / 9);
    end
    is_last = out_row >= h - 1 && out_col >= w - 1;
    centers_due.push_back('{mean: mean, gray: win[1][1], last: is_last});

    if (is_last) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    center_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (centers_due.size() == 0) begin
        flag_mismatch("unexpected transfer", out_mean_pixel, 0);
      end else begin
        want = centers_due.pop_front();
        if (out_mean_pixel !== want.mean) flag_mismatch("mean_pixel", out_mean_pixel, want.mean);
        if (out_gray_pixel !== want.gray) flag_mismatch("gray_pixel", out_gray_pixel, want.gray);
        if (out_frame_last !== want.last) flag_mismatch("frame_last", out_frame_last, want.last);
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is drawn, so it is
  // never lowered and raised in the same step.
  task automatic send_item(input logic req, input logic [PIX_W-1:0] a,
                           input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_chan_a <= a;
    in_chan_b <= b;
    in_chan_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blur_accept(req, a, b, c);
  endtask

  // Waits until every queued center has come out and the pipeline has emptied.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        model_width = val;
        restart_positions();
      end
      CFG_IMAGE_HEIGHT: begin
        model_height = val;
        restart_positions();
      end
      CFG_CHANNEL_MODE: model_mode = val[MODE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One whole frame and its drain; a negative level means random channels.
  task automatic send_frame(input int noise_pct, input int level);
    int n;
    for (n = 0; n < frame_w() * frame_h(); n++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
      if (level < 0) send_item(REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
      else send_item(REQ_PIXEL, PIX_W'(level), PIX_W'(level), PIX_W'(level));
    end
    // Pixels that arrive during the drain count as flush ticks.
    for (n = 0; n <= frame_w(); n++)
      send_item(1'($urandom_range(1)), rand_chan(), rand_chan(), rand_chan());
    if ($urandom_range(3) == 0) send_item(REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
  endtask

  // Only the width is written, so the height and the channel mode keep their
  // reset values; the rows after the first give interior centers in three-channel
  // mode. The frame is abandoned by the next size write.
  task automatic test_reset_defaults();
    int n;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    for (n = 0; n < 24; n++) begin
      if (n == 10) send_item(REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
      send_item(REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    finish_phase();
  endtask

  task automatic test_extreme_levels();
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_THREE));
    send_frame(0, 255);
    send_frame(0, 0);
    finish_phase();
  endtask

  task automatic test_flush_and_drain();
    int n;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    for (n = 0; n < 9; n++) begin
      // A flush tick in the middle of the frame is dropped.
      if (n == 4) send_item(REQ_FLUSH, '1, '1, '1);
      send_item(REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    send_item(REQ_PIXEL, '1, '1, '1);
    send_item(REQ_FLUSH, '0, '0, '0);
    send_item(REQ_PIXEL, '1, '0, '1);
    send_item(REQ_FLUSH, '1, '1, '1);
    // The frame is over; this one is dropped as well.
    send_item(REQ_FLUSH, '0, '0, '0);
    finish_phase();
  endtask

  task automatic test_channel_modes();
    logic [CFG_DATA_W-1:0] modes [4];
    int i;
    modes[0] = CFG_DATA_W'(MODE_ONE);
    modes[1] = CFG_DATA_W'(MODE_TWO);
    modes[2] = CFG_DATA_W'(MODE_THREE);
    // Upper data bits are dropped, leaving a code that acts as one channel.
    modes[3] = {10'h3FF, MODE_NONE};
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    for (i = 0; i < 4; i++) begin
      write_reg(CFG_CHANNEL_MODE, modes[i]);
      send_frame(0, -1);
      finish_phase();
    end
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED, '1);
    send_frame(10, -1);
    finish_phase();
  endtask

  task automatic test_random_frames();
    int start, done, n;
    start = items_taken;
    while (items_taken - start < RANDOM_ITEMS) begin
      done = items_taken - start;
      // A stretch in the middle runs with no gaps and no stalls.
      idle_pct = (done >= 300 && done < 550) ? 0 : 15;
      stall_pct = idle_pct;
      if ($urandom_range(2) == 0) begin
        finish_phase();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(12, 0)));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(8, 1)));
        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'($urandom_range(3, 0)));
      end
      if ($urandom_range(9) == 0) begin
        // Broken frame: cut short, then restarted by rewriting the height.
        for (n = $urandom_range(frame_w() * frame_h() - 1, 1); n > 0; n--)
          send_item(REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
        finish_phase();
        write_reg(CFG_IMAGE_HEIGHT, model_height);
      end else begin
        send_frame(5, -1);
      end
    end
    idle_pct = 15;
    stall_pct = 15;
  endtask

  initial begin
    foreach (row_store[i]) row_store[i] = '0;
    foreach (win[r, k]) win[r][k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extreme_levels();
    test_flush_and_drain();
    test_channel_modes();
    test_unused_index();
    test_random_frames();
    finish_phase();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
src/gbb_pkg.sv
src/gbb_ram.sv
src/gbb_ctrl.sv
src/gbb_filter.sv
src/gray_box_blur_3x3_unit.sv
test/gray_box_blur_3x3_unit_tb.sv
